[rtl/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and codes for the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
package cau_pkg;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } cau_mode_t;

  // sideband carried along the divider chain
  typedef struct packed {
    logic is_div;
    logic neg_re;
    logic neg_im;
    logic ovp_re;
    logic ovp_im;
    logic ovf;
    logic dz;
  } cau_flags_t;

endpackage
`default_nettype wire

[rtl/cau_div_cell.sv]
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring-division cell: settles quotient bit BIT of both parts.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_div_cell #(
  parameter int W   = 32,
  parameter int PW  = 64,
  parameter int RW  = 112,
  parameter int BIT = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                v_in,
  input  cau_pkg::cau_flags_t fl_in,
  input  logic [PW-1:0]       den_in,
  input  logic [RW-1:0]       rre_in,
  input  logic [RW-1:0]       rim_in,
  input  logic [W-1:0]        qre_in,
  input  logic [W-1:0]        qim_in,
  input  logic [W-1:0]        pre_in,
  input  logic [W-1:0]        pim_in,
  output logic                v_out,
  output cau_pkg::cau_flags_t fl_out,
  output logic [PW-1:0]       den_out,
  output logic [RW-1:0]       rre_out,
  output logic [RW-1:0]       rim_out,
  output logic [W-1:0]        qre_out,
  output logic [W-1:0]        qim_out,
  output logic [W-1:0]        pre_out,
  output logic [W-1:0]        pim_out
);
  import cau_pkg::*;

  logic [RW-1:0] dd;
  logic          ge_re, ge_im;

  assign dd    = RW'(den_in) << BIT;
  assign ge_re = rre_in >= dd;
  assign ge_im = rim_in >= dd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (adv) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fl_out  <= fl_in;
      den_out <= den_in;
      rre_out <= ge_re ? rre_in - dd : rre_in;
      rim_out <= ge_im ? rim_in - dd : rim_in;
      qre_out <= qre_in | (W'(ge_re) << BIT);
      qim_out <= qim_in | (W'(ge_im) << BIT);
      pre_out <= pre_in;
      pim_out <= pim_in;
    end
  end
endmodule
`default_nettype wire

[rtl/complex_arithmetic_unit_core.sv]
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Complex add, subtract, multiply and divide in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one item per cycle while the result side does not stall and
// returns each result through one multiplier stage, one setup stage, a chain of
// DATA_WIDTH division cells (one quotient bit each) and an output register.
// Every mode passes through the same chain, so results leave in order. A
// stall on the result side freezes the whole pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module complex_arithmetic_unit_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         op_valid,
  output logic                         op_stall,
  input  logic [1:0]                   mode,
  input  logic signed [DATA_WIDTH-1:0] a_re,
  input  logic signed [DATA_WIDTH-1:0] a_im,
  input  logic signed [DATA_WIDTH-1:0] b_re,
  input  logic signed [DATA_WIDTH-1:0] b_im,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic signed [DATA_WIDTH-1:0] res_re,
  output logic signed [DATA_WIDTH-1:0] res_im,
  output logic                         overflow,
  output logic                         div_by_zero
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int SW = PW + 1;
  localparam int RW = 3 * W + F;
  localparam logic signed [SW-1:0] MAXV = (SW'(1) << (W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] MINV = -(SW'(1) << (W - 1));
  localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W:0] sat(input logic signed [SW-1:0] x);
    logic [W:0] r;
    if (x > MAXV) begin
      r = {1'b1, MAXW};
    end else if (x < MINV) begin
      r = {1'b1, MINW};
    end else begin
      r = {1'b0, x[W-1:0]};
    end
    return r;
  endfunction

  logic adv;
  assign adv      = !(res_valid && res_stall);
  assign op_stall = !adv;

  // multiplier stage
  logic                v1;
  cau_mode_t           md1;
  logic signed [W-1:0] ar1, ai1, br1, bi1;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      md1  <= cau_mode_t'(mode);
      ar1  <= a_re;
      ai1  <= a_im;
      br1  <= b_re;
      bi1  <= b_im;
      p_rr <= PW'(a_re) * PW'(b_re);
      p_ii <= PW'(a_im) * PW'(b_im);
      p_ri <= PW'(a_re) * PW'(b_im);
      p_ir <= PW'(a_im) * PW'(b_re);
      p_bb <= PW'(b_re) * PW'(b_re);
      p_cc <= PW'(b_im) * PW'(b_im);
    end
  end

  // setup stage
  logic signed [SW-1:0] m_re, m_im, n_re, n_im, s_re, s_im, ab_re, ab_im;
  logic [PW-1:0]        den;
  logic [RW-1:0]        num_re, num_im, den_w;
  logic [W:0]           sr_re, sr_im;
  cau_flags_t           fl2_next;
  logic [W-1:0]         pre2_next, pim2_next;

  always_comb begin
    m_re  = SW'(p_rr) - SW'(p_ii);
    m_im  = SW'(p_ri) + SW'(p_ir);
    n_re  = SW'(p_rr) + SW'(p_ii);
    n_im  = SW'(p_ir) - SW'(p_ri);
    den   = PW'(p_bb) + PW'(p_cc);
    ab_re = n_re[SW-1] ? -n_re : n_re;
    ab_im = n_im[SW-1] ? -n_im : n_im;
    num_re = RW'(ab_re[PW-1:0]) << F;
    num_im = RW'(ab_im[PW-1:0]) << F;
    den_w  = RW'(den) << W;
    s_re = '0;
    s_im = '0;
    case (md1)
      MODE_ADD: begin
        s_re = SW'(ar1) + SW'(br1);
        s_im = SW'(ai1) + SW'(bi1);
      end
      MODE_SUB: begin
        s_re = SW'(ar1) - SW'(br1);
        s_im = SW'(ai1) - SW'(bi1);
      end
      MODE_MUL: begin
        s_re = m_re >>> F;
        s_im = m_im >>> F;
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
    sr_re = sat(s_re);
    sr_im = sat(s_im);
    fl2_next.is_div = (md1 == MODE_DIV) && (den != '0);
    fl2_next.neg_re = n_re[SW-1];
    fl2_next.neg_im = n_im[SW-1];
    fl2_next.ovp_re = num_re >= den_w;
    fl2_next.ovp_im = num_im >= den_w;
    fl2_next.ovf    = sr_re[W] | sr_im[W];
    fl2_next.dz     = (md1 == MODE_DIV) && (den == '0);
    pre2_next = sr_re[W-1:0];
    pim2_next = sr_im[W-1:0];
  end

  logic                v_c   [0:W];
  cau_flags_t          fl_c  [0:W];
  logic [PW-1:0]       den_c [0:W];
  logic [RW-1:0]       rre_c [0:W];
  logic [RW-1:0]       rim_c [0:W];
  logic [W-1:0]        qre_c [0:W];
  logic [W-1:0]        qim_c [0:W];
  logic [W-1:0]        pre_c [0:W];
  logic [W-1:0]        pim_c [0:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c[0] <= 1'b0;
    end else if (adv) begin
      v_c[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fl_c[0]  <= fl2_next;
      den_c[0] <= den;
      rre_c[0] <= num_re;
      rim_c[0] <= num_im;
      qre_c[0] <= '0;
      qim_c[0] <= '0;
      pre_c[0] <= pre2_next;
      pim_c[0] <= pim2_next;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_cell
    cau_div_cell #(.W(W), .PW(PW), .RW(RW), .BIT(W - 1 - k)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .v_in   (v_c[k]),
      .fl_in  (fl_c[k]),
      .den_in (den_c[k]),
      .rre_in (rre_c[k]),
      .rim_in (rim_c[k]),
      .qre_in (qre_c[k]),
      .qim_in (qim_c[k]),
      .pre_in (pre_c[k]),
      .pim_in (pim_c[k]),
      .v_out  (v_c[k+1]),
      .fl_out (fl_c[k+1]),
      .den_out(den_c[k+1]),
      .rre_out(rre_c[k+1]),
      .rim_out(rim_c[k+1]),
      .qre_out(qre_c[k+1]),
      .qim_out(qim_c[k+1]),
      .pre_out(pre_c[k+1]),
      .pim_out(pim_c[k+1])
    );
  end

  // output stage
  cau_flags_t     fe;
  logic [W:0]     fr_re, fr_im;
  logic [W-1:0]   o_re_next, o_im_next;
  logic           o_ovf_next;

  always_comb begin
    fe = fl_c[W];
    if (fe.ovp_re) begin
      fr_re = {1'b1, fe.neg_re ? MINW : MAXW};
    end else begin
      fr_re = sat(fe.neg_re ? -SW'(qre_c[W]) : SW'(qre_c[W]));
    end
    if (fe.ovp_im) begin
      fr_im = {1'b1, fe.neg_im ? MINW : MAXW};
    end else begin
      fr_im = sat(fe.neg_im ? -SW'(qim_c[W]) : SW'(qim_c[W]));
    end
    if (fe.is_div) begin
      o_re_next  = fr_re[W-1:0];
      o_im_next  = fr_im[W-1:0];
      o_ovf_next = fr_re[W] | fr_im[W];
    end else begin
      o_re_next  = pre_c[W];
      o_im_next  = pim_c[W];
      o_ovf_next = fe.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= v_c[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_re      <= o_re_next;
      res_im      <= o_im_next;
      overflow    <= o_ovf_next;
      div_by_zero <= fe.dz;
    end
  end
endmodule
`default_nettype wire

[rtl/cau_checker.sv]
// ----------------------------------------------------------------------------
// cau_props
// Port-level checks for the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_props #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         op_stall,
  input logic                         res_valid,
  input logic                         res_stall,
  input logic signed [DATA_WIDTH-1:0] res_re,
  input logic signed [DATA_WIDTH-1:0] res_im,
  input logic                         overflow,
  input logic                         div_by_zero
);
  localparam logic [DATA_WIDTH-1:0] MAXW = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MINW = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_re) && $stable(res_im))
    else $error("stalled item changed");

  a_back: assert property (@(posedge clk) disable iff (rst)
    op_stall |-> res_valid && res_stall)
    else $error("input stalled without output stall");

  a_dz: assert property (@(posedge clk) disable iff (rst)
    res_valid && div_by_zero |-> res_re == '0 && res_im == '0 && !overflow)
    else $error("divide by zero item not cleared");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    res_valid && overflow |->
      res_re == MAXW || res_re == MINW || res_im == MAXW || res_im == MINW)
    else $error("overflow without saturated part");
endmodule

bind complex_arithmetic_unit_core cau_props #(.DATA_WIDTH(DATA_WIDTH)) u_cau_props (
  .clk        (clk),
  .rst        (rst),
  .op_stall   (op_stall),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .res_re     (res_re),
  .res_im     (res_im),
  .overflow   (overflow),
  .div_by_zero(div_by_zero)
);
`default_nettype wire

[bench/cau_checker.sv]
// ----------------------------------------------------------------------------
// cau_checker
// Watches both channels of the complex arithmetic unit, predicts each result
// from the accepted operands with wide exact arithmetic and compares fields.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  input  logic               op_stall,
  input  logic [1:0]         mode,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  input  logic               res_valid,
  input  logic               res_stall,
  input  logic signed [31:0] res_re,
  input  logic signed [31:0] res_im,
  input  logic               overflow,
  input  logic               div_by_zero,
  output int                 errors,
  output int                 pending
);
  import cau_pkg::*;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               ovf;
    logic               dz;
  } cau_result_t;

  cau_result_t expected_results[$];

  function automatic logic signed [31:0] clamp(input logic signed [127:0] v,
                                               inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // truncating division toward zero on magnitudes; den is positive
  function automatic logic signed [127:0] quot(input logic signed [127:0] num,
                                               input logic signed [127:0] den);
    logic [127:0] mag;
    mag = (num < 0) ? -num : num;
    mag = (mag << 16) / den;
    return (num < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic cau_result_t complex_result(input cau_mode_t m,
      input logic signed [31:0] ar, ai, br, bi);
    cau_result_t r;
    logic signed [127:0] xr, xi, xbr, xbi, pre, pim, den;
    logic ovf;
    xr = ar; xi = ai; xbr = br; xbi = bi;
    ovf = 1'b0;
    r.dz = 1'b0;
    case (m)
      MODE_ADD: begin pre = xr + xbr; pim = xi + xbi; end
      MODE_SUB: begin pre = xr - xbr; pim = xi - xbi; end
      MODE_MUL: begin
        pre = (xr * xbr - xi * xbi) >>> 16;
        pim = (xr * xbi + xi * xbr) >>> 16;
      end
      default: begin
        den = xbr * xbr + xbi * xbi;
        if (den == 0) begin
          r.dz = 1'b1;
          pre = 0;
          pim = 0;
        end else begin
          pre = quot(xr * xbr + xi * xbi, den);
          pim = quot(xi * xbr - xr * xbi, den);
        end
      end
    endcase
    r.re = clamp(pre, ovf);
    r.im = clamp(pim, ovf);
    r.ovf = ovf;
    return r;
  endfunction

  always @(posedge clk) begin
    cau_result_t e;
    if (rst) begin
      errors <= 0;
    end else begin
      if (op_valid && !op_stall)
        expected_results.push_back(complex_result(cau_mode_t'(mode), a_re, a_im, b_re, b_im));
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          if (errors < 10) $display("unexpected result %h %h", res_re, res_im);
          errors <= errors + 1;
        end else begin
          e = expected_results.pop_front();
          if (e.re !== res_re || e.im !== res_im || e.ovf !== overflow ||
              e.dz !== div_by_zero) begin
            if (errors < 10)
              $display("mismatch exp re=%h im=%h ovf=%b dz=%b got re=%h im=%h ovf=%b dz=%b",
                       e.re, e.im, e.ovf, e.dz, res_re, res_im, overflow, div_by_zero);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  assign pending = expected_results.size();
endmodule
`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random operand pairs into the complex arithmetic unit
// with random gaps and stalls, including a long result-side hold-off.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import cau_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic op_valid = 1'b0;
  logic op_stall;
  logic [1:0] mode = MODE_ADD;
  logic signed [31:0] a_re = 0, a_im = 0, b_re = 0, b_im = 0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic signed [31:0] res_re, res_im;
  logic overflow, div_by_zero;
  int errors, pending;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  complex_arithmetic_unit_core uut (.*);

  cau_checker chk (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] operand();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      4: return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input cau_mode_t m, input logic signed [31:0] ar, ai, br, bi);
    mode <= m; a_re <= ar; a_im <= ai; b_re <= br; b_im <= bi;
    op_valid <= 1'b1;
    do @(posedge clk); while (op_stall);
  endtask

  task automatic pause_sender();
    int n;
    n = gap_len();
    if (n > 0) begin
      op_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // receiver stalls; one long hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_off) begin
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    wait (!rst);
    repeat (300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if ((op_valid && !op_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    logic signed [31:0] ext[4];
    int i;
    ext = '{32'sh7fffffff, 32'sh80000000, 0, 32'sh00010000};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (i = 0; i < 4; i++) begin
      send(cau_mode_t'(i), ext[0], ext[1], ext[0], ext[1]);
      send(cau_mode_t'(i), ext[1], ext[1], ext[1], ext[1]);
      send(cau_mode_t'(i), ext[0], ext[0], ext[0], ext[0]);
      send(cau_mode_t'(i), ext[3], -ext[3], 32'sh00020000, 32'sh00008000);
      send(cau_mode_t'(i), 32'sh12345678, 32'shfedcba98, 0, 0);
    end
    send(MODE_DIV, ext[0], ext[1], 1, 0);
    send(MODE_DIV, ext[1], ext[1], 0, 1);
    send(MODE_MUL, -1, 1, 1, 1);
    for (i = 0; i < 400; i++) begin
      send(cau_mode_t'($urandom_range(0, 3)), operand(), operand(), operand(), operand());
      if (!hold_off && i % 50 > 25) pause_sender();
    end
    op_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
